@@ design/kdenc_pkg.sv @@
// Shared types, constants and the quadrature step table for the key debounce
// and encoder detent block. Has no dependencies of its own.
`default_nettype none
package kdenc_pkg;

  // Switch counts: the matrix keys plus the encoder push switch.
  localparam int NUM_MECH_KEYS = 6;
  localparam int NUM_DEB       = NUM_MECH_KEYS + 1;

  // Timestamp width and the half range that marks an expired pulse.
  localparam int TIME_BITS = 32;
  localparam logic [TIME_BITS-1:0] TIME_HALF = {1'b0, {(TIME_BITS-1){1'b1}}};

  // Signed step accumulator, saturating at plus or minus 32767 (ACC_MAX, ACC_MIN).
  localparam int ACC_W = 16;
  localparam int SUM_W = ACC_W + 1;
  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -SUM_W'(32767);

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_DETENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MS = 2'd2;

  // Register reset values.
  localparam logic [7:0] DEBOUNCE_MS_RST = 8'd5;
  localparam logic [4:0] STEPS_PER_DETENT_RST = 5'd4;
  localparam logic [7:0] PULSE_MS_RST = 8'd20;

  // Encoder settings handed from the register file to the decoder.
  typedef struct packed {
    logic [4:0] steps_per_detent;
    logic [7:0] pulse_ms;
  } enc_cfg_t;

  // Quadrature step for a {prior A, prior B, current A, current B} index.
  // Unchanged phases and double transitions give zero.
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] step;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: step = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
      default: step = 2'sd0;
    endcase
    return step;
  endfunction

endpackage
`default_nettype wire

@@ design/key_debounce_and_encoder_detent_top.sv @@
// Top level: stream ports, configuration registers, input and result registers.
// Depends on kdenc_pkg, kdenc_debounce and kdenc_encoder.
// An accepted item waits in the input register and moves into the result register
// once that is empty or being emptied; it shows on out_tdata from then on.
// Throughput: one item per cycle with out_tready high; updates are combinational.
// Reset: synchronous active-low rst_n clears all but the data registers and loads
// the defaults (debounce 5 ms, 4 steps per detent, 20 ms pulse); no clearing pass.
`default_nettype none
module key_debounce_and_encoder_detent_top (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // Input item, from bit 0: raw_keys[5:0], raw_switch, phase_a, phase_b,
  // now_ms[31:0], zero padding.
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire [kdenc_pkg::IN_DATA_W-1:0]      in_tdata,
  // Result item, from bit 0: stable_keys[5:0], stable_switch, rotate_cw,
  // rotate_ccw, zero padding.
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [kdenc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  wire                                 cfg_we,
  input  wire [kdenc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [kdenc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import kdenc_pkg::*;

  localparam int PAY_W = NUM_DEB + 2;

  logic [7:0]           debounce_ms_r;
  enc_cfg_t             enc_cfg_r;
  logic                 in_valid_r;
  logic [IN_DATA_W-1:0] in_data_r;
  logic                 out_valid_r;
  logic [PAY_W-1:0]     out_data_r;
  logic                 advance;
  logic [NUM_DEB-1:0]   stable_bits;
  logic                 rotate_cw;
  logic                 rotate_ccw;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r              <= DEBOUNCE_MS_RST;
      enc_cfg_r.steps_per_detent <= STEPS_PER_DETENT_RST;
      enc_cfg_r.pulse_ms         <= PULSE_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS:      debounce_ms_r <= cfg_data;
        REG_STEPS_PER_DETENT: enc_cfg_r.steps_per_detent <= cfg_data[4:0];
        REG_PULSE_MS:         enc_cfg_r.pulse_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // An item moves from the input register into the result register whenever
  // the result register is empty or being emptied in the same cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  kdenc_debounce u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .raw_bits    (in_data_r[NUM_DEB-1:0]),
    .now_ms      (in_data_r[NUM_DEB+2 +: TIME_BITS]),
    .debounce_ms (debounce_ms_r),
    .stable_bits (stable_bits)
  );

  kdenc_encoder u_encoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .phase_a    (in_data_r[NUM_DEB]),
    .phase_b    (in_data_r[NUM_DEB+1]),
    .now_ms     (in_data_r[NUM_DEB+2 +: TIME_BITS]),
    .cfg        (enc_cfg_r),
    .rotate_cw  (rotate_cw),
    .rotate_ccw (rotate_ccw)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {rotate_ccw, rotate_cw, stable_bits};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

endmodule
`default_nettype wire

@@ design/kdenc_debounce.sv @@
// Debounce bank: one independent window per key and for the push switch.
// Depends on kdenc_pkg.
`default_nettype none
module kdenc_debounce (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  en,
  input  wire [kdenc_pkg::NUM_DEB-1:0]         raw_bits,
  input  wire [kdenc_pkg::TIME_BITS-1:0]       now_ms,
  input  wire [7:0]                            debounce_ms,
  output logic [kdenc_pkg::NUM_DEB-1:0]        stable_bits
);
  import kdenc_pkg::*;

  logic [NUM_DEB-1:0]   last_raw_r, last_raw_nxt;
  logic [NUM_DEB-1:0]   stable_r, stable_nxt;
  logic [TIME_BITS-1:0] stamp_r [NUM_DEB];
  logic [TIME_BITS-1:0] stamp_nxt [NUM_DEB];
  logic [TIME_BITS-1:0] elapsed [NUM_DEB];
  logic [TIME_BITS-1:0] window;

  assign window = TIME_BITS'(debounce_ms);

  // Each lane restarts its window on a raw change and accepts a steady reading.
  always_comb begin
    last_raw_nxt = last_raw_r;
    stable_nxt   = stable_r;
    for (int i = 0; i < NUM_DEB; i++) begin
      stamp_nxt[i] = stamp_r[i];
      elapsed[i]   = now_ms - stamp_r[i];
      if (raw_bits[i] != last_raw_r[i]) begin
        last_raw_nxt[i] = raw_bits[i];
        stamp_nxt[i]    = now_ms;
      end else if (raw_bits[i] != stable_r[i] && elapsed[i] >= window) begin
        stable_nxt[i] = raw_bits[i];
      end
    end
  end

  // Lane state advances only when an item is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= '0;
      stable_r   <= '0;
      for (int i = 0; i < NUM_DEB; i++) begin
        stamp_r[i] <= '0;
      end
    end else if (en) begin
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      for (int i = 0; i < NUM_DEB; i++) begin
        stamp_r[i] <= stamp_nxt[i];
      end
    end
  end

  // The result item carries the state after this item.
  assign stable_bits = stable_nxt;

endmodule
`default_nettype wire

@@ design/kdenc_encoder.sv @@
// Quadrature decoder with saturating step count and detent pulse generator.
// Depends on kdenc_pkg.
`default_nettype none
module kdenc_encoder (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              en,
  input  wire                              phase_a,
  input  wire                              phase_b,
  input  wire [kdenc_pkg::TIME_BITS-1:0]   now_ms,
  input  wire kdenc_pkg::enc_cfg_t         cfg,
  output logic                             rotate_cw,
  output logic                             rotate_ccw
);
  import kdenc_pkg::*;

  logic                    seeded_r, seeded_nxt;
  logic [1:0]              prior_r, prior_nxt;
  logic signed [ACC_W-1:0] accum_r, accum_nxt;
  logic                    active_r, active_nxt;
  logic [TIME_BITS-1:0]    deadline_r, deadline_nxt;
  logic                    is_ccw_r, is_ccw_nxt;

  logic [1:0]              phase;
  logic signed [SUM_W-1:0] acc_ext;
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [SUM_W-1:0] acc_step;
  logic signed [SUM_W-1:0] detent;
  logic [4:0]              detent_u;
  logic [TIME_BITS-1:0]    since_deadline;
  logic [TIME_BITS-1:0]    new_deadline;

  assign phase    = {phase_a, phase_b};
  assign acc_ext  = SUM_W'(accum_r);
  assign detent_u = (cfg.steps_per_detent == 5'd0) ? 5'd1 : cfg.steps_per_detent;
  assign detent   = SUM_W'($signed({1'b0, detent_u}));
  assign since_deadline = now_ms - deadline_r;
  assign new_deadline   = now_ms + TIME_BITS'(cfg.pulse_ms);

  // Phase tracking and the saturating step accumulator.
  always_comb begin
    seeded_nxt = 1'b1;
    prior_nxt  = prior_r;
    acc_sum    = acc_ext + SUM_W'(quad_step({prior_r, phase}));
    acc_step   = acc_ext;
    if (!seeded_r) begin
      prior_nxt = phase;
    end else if (phase != prior_r) begin
      prior_nxt = phase;
      if (acc_sum > ACC_MAX) begin
        acc_step = ACC_MAX;
      end else if (acc_sum < ACC_MIN) begin
        acc_step = ACC_MIN;
      end else begin
        acc_step = acc_sum;
      end
    end
  end

  // Pulse handling: a running pulse ends once its deadline is reached;
  // otherwise a full detent in either direction starts a new one.
  always_comb begin
    active_nxt   = active_r;
    deadline_nxt = deadline_r;
    is_ccw_nxt   = is_ccw_r;
    accum_nxt    = acc_step[ACC_W-1:0];
    rotate_cw    = 1'b0;
    rotate_ccw   = 1'b0;
    if (active_r) begin
      if (since_deadline < TIME_HALF) begin
        active_nxt = 1'b0;
      end else begin
        rotate_cw  = !is_ccw_r;
        rotate_ccw = is_ccw_r;
      end
    end else if (acc_step >= detent) begin
      accum_nxt    = ACC_W'(acc_step - detent);
      active_nxt   = 1'b1;
      is_ccw_nxt   = 1'b0;
      deadline_nxt = new_deadline;
      rotate_cw    = 1'b1;
    end else if (acc_step <= -detent) begin
      accum_nxt    = ACC_W'(acc_step + detent);
      active_nxt   = 1'b1;
      is_ccw_nxt   = 1'b1;
      deadline_nxt = new_deadline;
      rotate_ccw   = 1'b1;
    end
  end

  // Decoder state advances only when an item is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r   <= 1'b0;
      prior_r    <= 2'b00;
      accum_r    <= '0;
      active_r   <= 1'b0;
      deadline_r <= '0;
      is_ccw_r   <= 1'b0;
    end else if (en) begin
      seeded_r   <= seeded_nxt;
      prior_r    <= prior_nxt;
      accum_r    <= accum_nxt;
      active_r   <= active_nxt;
      deadline_r <= deadline_nxt;
      is_ccw_r   <= is_ccw_nxt;
    end
  end

endmodule
`default_nettype wire

@@ tb/kdenc_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the key debounce and encoder detent block: follows the register
// writes, predicts every result item from the accepted scans and compares.
// Depends on kdenc_pkg for widths, register indexes and reset values.
module kdenc_checker (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  input  wire                               in_tready,
  input  wire [kdenc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire                               out_tvalid,
  input  wire                               out_tready,
  input  wire [kdenc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  wire                               cfg_we,
  input  wire [kdenc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [kdenc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fail_count,
  output int                                pending,
  output int                                scans_seen,
  output int                                results_seen,
  output int                                cw_starts,
  output int                                ccw_starts,
  output int                                sat_hits,
  output bit                                pulse_held
);
  import kdenc_pkg::*;

  localparam int STEP_LIMIT = 32767;

  // One scan, packed from bit 0 up as on in_tdata.
  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] now_ms;
    logic        phase_b;
    logic        phase_a;
    logic        raw_switch;
    logic [5:0]  raw_keys;
  } scan_t;

  // One result, packed from bit 0 up as on out_tdata.
  typedef struct packed {
    logic [6:0] pad;
    logic       rotate_ccw;
    logic       rotate_cw;
    logic       stable_switch;
    logic [5:0] stable_keys;
  } keys_t;

  // Register copies.
  logic [7:0]  debounce_cfg;
  logic [4:0]  detent_cfg;
  logic [7:0]  pulse_cfg;

  // Debounce state: bits 0..5 are the keys, bit 6 the push switch.
  logic [6:0]  debounced;
  logic [6:0]  last_raw;
  logic [31:0] raw_since [NUM_DEB];

  // Encoder and pulse state.
  bit          phase_known;
  logic [1:0]  last_phase;
  int          step_count;
  logic [31:0] pulse_end;
  bit          pulse_ccw;

  keys_t       expected_keys_q [$];

  // Quadrature step for {prior A, prior B, current A, current B}.
  function automatic int quad_delta(input logic [3:0] idx);
    int d;
    case (idx)
      4'd2, 4'd4, 4'd11, 4'd13: d = 1;
      4'd1, 4'd7, 4'd8, 4'd14:  d = -1;
      default:                  d = 0;
    endcase
    return d;
  endfunction

  // Advances the predicted state by one scan and returns the result it gives.
  function automatic keys_t scan_to_keys(input scan_t s);
    logic [6:0] raw;
    logic [1:0] ph;
    int         detent;
    keys_t      r;
    raw = {s.raw_switch, s.raw_keys};
    ph = {s.phase_a, s.phase_b};
    detent = (detent_cfg == 5'd0) ? 1 : int'(detent_cfg);
    r = '0;

    // Each switch restarts its window on a raw change and settles once steady.
    for (int i = 0; i < NUM_DEB; i++) begin
      if (raw[i] != last_raw[i]) begin
        last_raw[i] = raw[i];
        raw_since[i] = s.now_ms;
      end else if (raw[i] != debounced[i] &&
                   (s.now_ms - raw_since[i]) >= {24'd0, debounce_cfg}) begin
        debounced[i] = raw[i];
      end
    end

    // The first scan only records the phase; later changes step the count.
    if (!phase_known) begin
      phase_known = 1'b1;
      last_phase = ph;
    end else if (ph != last_phase) begin
      step_count += quad_delta({last_phase, ph});
      if (step_count > STEP_LIMIT) begin
        step_count = STEP_LIMIT;
        sat_hits++;
      end
      if (step_count < -STEP_LIMIT) begin
        step_count = -STEP_LIMIT;
        sat_hits++;
      end
      last_phase = ph;
    end

    // A running pulse ends once its deadline lies in the past half range.
    if (pulse_held) begin
      if ((s.now_ms - pulse_end) < TIME_HALF) begin
        pulse_held = 1'b0;
      end else begin
        r.rotate_cw = !pulse_ccw;
        r.rotate_ccw = pulse_ccw;
      end
    end else if (step_count >= detent) begin
      step_count -= detent;
      pulse_held = 1'b1;
      pulse_ccw = 1'b0;
      pulse_end = s.now_ms + {24'd0, pulse_cfg};
      r.rotate_cw = 1'b1;
      cw_starts++;
    end else if (step_count <= -detent) begin
      step_count += detent;
      pulse_held = 1'b1;
      pulse_ccw = 1'b1;
      pulse_end = s.now_ms + {24'd0, pulse_cfg};
      r.rotate_ccw = 1'b1;
      ccw_starts++;
    end

    r.stable_keys = debounced[5:0];
    r.stable_switch = debounced[6];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Everything is sampled at the rising edge; stimulus moves at the falling one.
  always @(posedge clk) begin : watch
    keys_t got;
    keys_t want;
    if (!rst_n) begin
      debounce_cfg = DEBOUNCE_MS_RST;
      detent_cfg = STEPS_PER_DETENT_RST;
      pulse_cfg = PULSE_MS_RST;
      debounced = '0;
      last_raw = '0;
      for (int i = 0; i < NUM_DEB; i++) raw_since[i] = '0;
      phase_known = 1'b0;
      last_phase = 2'b00;
      step_count = 0;
      pulse_held = 1'b0;
      pulse_end = '0;
      pulse_ccw = 1'b0;
      expected_keys_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE_MS:      debounce_cfg = cfg_data;
          REG_STEPS_PER_DETENT: detent_cfg = cfg_data[4:0];
          REG_PULSE_MS:         pulse_cfg = cfg_data;
          default: ;
        endcase
      end

      // Compare a delivered result with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got = keys_t'(out_tdata);
        results_seen++;
        if (expected_keys_q.size() == 0) begin
          $error("result %h arrived with no scan waiting", out_tdata);
          fail_count++;
        end else begin
          want = expected_keys_q.pop_front();
          check_field("stable_keys", want.stable_keys, got.stable_keys);
          check_field("stable_switch", want.stable_switch, got.stable_switch);
          check_field("rotate_cw", want.rotate_cw, got.rotate_cw);
          check_field("rotate_ccw", want.rotate_ccw, got.rotate_ccw);
          check_field("padding", want.pad, got.pad);
        end
      end

      if (in_tvalid && in_tready) begin
        scans_seen++;
        expected_keys_q.push_back(scan_to_keys(scan_t'(in_tdata)));
      end
    end
    pending = expected_keys_q.size();
  end

endmodule

@@ tb/tb_key_debounce_and_encoder_detent_top.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for key_debounce_and_encoder_detent_top: directed scans,
// random scan streams under several register settings and a frozen-time pile-up.
// Depends on kdenc_pkg, the block itself and kdenc_checker.
module tb_key_debounce_and_encoder_detent_top;
  import kdenc_pkg::*;

  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_SCANS  = 65;
  localparam int PILE_STEPS   = 24;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // raw_keys[5:0], raw_switch, phase_a, phase_b, now_ms[31:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // stable_keys[5:0], stable_switch, rotate_cw, rotate_ccw
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int scans_seen;
  int results_seen;
  int cw_starts;
  int ccw_starts;
  int sat_hits;
  bit pulse_held;

  // no_idle and hold_req are shared between the scan source and the result sink.
  bit no_idle;
  int hold_req;
  int settings_used;

  // Current scan contents; the encoder phase is {A, B}.
  logic [5:0]  cur_keys;
  logic        cur_sw;
  logic [1:0]  cur_ph;
  logic [31:0] cur_t;
  bit          turn_ccw;

  key_debounce_and_encoder_detent_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kdenc_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .scans_seen(scans_seen),
    .results_seen(results_seen), .cw_starts(cw_starts), .ccw_starts(ccw_starts),
    .sat_hits(sat_hits), .pulse_held(pulse_held)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // One quadrature step in the chosen direction.
  function automatic logic [1:0] quad_next(input logic [1:0] ph, input bit ccw);
    logic [1:0] nxt;
    case (ph)
      2'b00:   nxt = ccw ? 2'b01 : 2'b10;
      2'b10:   nxt = ccw ? 2'b00 : 2'b11;
      2'b11:   nxt = ccw ? 2'b10 : 2'b01;
      default: nxt = ccw ? 2'b11 : 2'b00;
    endcase
    return nxt;
  endfunction

  // Offers one scan after a random gap (none while no_idle is set) and returns at the
  // falling edge after it was taken. Called at a falling edge.
  task automatic scan(input logic [5:0] keys, input logic sw, input logic [1:0] ph,
                      input logic [31:0] t);
    int gap;
    cur_keys = keys;
    cur_sw = sw;
    cur_ph = ph;
    cur_t = t;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, t, ph[0], ph[1], sw, keys};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly clean rotation with random direction changes, plus key bounce,
  // double transitions and time jumps.
  task automatic rand_scan();
    int          r;
    logic [5:0]  keys;
    logic [1:0]  ph;
    logic [31:0] t;
    keys = cur_keys;
    ph = cur_ph;
    t = cur_t;
    r = $urandom_range(0, 99);
    // A jump to any time is only made without a pulse running, so that a
    // pulse is not left waiting for half the time range.
    if (r < 2 && !pulse_held) t = $urandom;
    else if (r < 10) t += $urandom_range(0, 600);
    else t += $urandom_range(0, 3);

    r = $urandom_range(0, 99);
    if (r < 8) keys = $urandom_range(0, 63);
    else if (r < 25) keys[$urandom_range(0, 5)] = ~keys[$urandom_range(0, 5)];
    if ($urandom_range(0, 9) == 0) cur_sw = ~cur_sw;

    if ($urandom_range(0, 99) < 8) turn_ccw = ~turn_ccw;
    r = $urandom_range(0, 99);
    if (r < 65) ph = quad_next(ph, turn_ccw);
    else if (r < 75) ph = ~ph;
    scan(keys, cur_sw, ph, t);
  endtask

  // Stops offering scans and waits until every result has been delivered.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes all three registers; only called while the block is idle.
  task automatic set_regs(input logic [7:0] deb, input logic [7:0] detent,
                          input logic [7:0] pulse);
    cfg_we <= 1'b1;
    cfg_index <= REG_DEBOUNCE_MS;
    cfg_data <= deb;
    @(negedge clk);
    cfg_index <= REG_STEPS_PER_DETENT;
    cfg_data <= detent;
    @(negedge clk);
    cfg_index <= REG_PULSE_MS;
    cfg_data <= pulse;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Result sink: a random stall before each result unless no_idle is set, and one
  // long hold-off whenever the source asks for it.
  initial begin : result_sink
    int holds_done;
    int low;
    holds_done = 0;
    out_tready <= 1'b0;
    @(negedge clk);
    forever begin
      low = no_idle ? 0 : $urandom_range(0, 9);
      if (hold_req != holds_done) begin
        low += LONG_HOLD;
        holds_done++;
      end
      repeat (low) begin
        out_tready <= 1'b0;
        @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Main sequence: reset, directed scans, random phases, frozen-time pile-up.
  initial begin : scan_source
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_DEBOUNCE_MS;
    cfg_data = '0;
    no_idle = 1'b0;
    hold_req = 0;
    settings_used = 1;
    cur_keys = '0;
    cur_sw = 1'b0;
    cur_ph = 2'b00;
    cur_t = '0;
    turn_ccw = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed scans under the reset settings (5 ms, 4 steps, 20 ms).
    // The first scan's phase would count a step if it were decoded.
    scan(6'h00, 1'b0, 2'b01, 32'd100);
    // Press everything; it settles only once 5 ms have passed.
    scan(6'h3F, 1'b1, 2'b01, 32'd101);
    scan(6'h3F, 1'b1, 2'b01, 32'd105);
    scan(6'h3F, 1'b1, 2'b01, 32'd106);
    // Bounce restarts the window.
    scan(6'h15, 1'b1, 2'b01, 32'd107);
    scan(6'h3F, 1'b1, 2'b01, 32'd108);
    // Four clockwise steps make a detent; the pulse runs until 136.
    scan(6'h3F, 1'b1, 2'b00, 32'd113);
    scan(6'h00, 1'b0, 2'b10, 32'd114);
    scan(6'h00, 1'b0, 2'b11, 32'd115);
    scan(6'h00, 1'b0, 2'b01, 32'd116);
    scan(6'h00, 1'b0, 2'b01, 32'd125);
    scan(6'h00, 1'b0, 2'b01, 32'd135);
    scan(6'h00, 1'b0, 2'b01, 32'd136);
    // Double transitions count nothing.
    scan(6'h00, 1'b0, 2'b10, 32'd137);
    scan(6'h00, 1'b0, 2'b01, 32'd138);
    // Counterclockwise detent whose deadline wraps past zero.
    scan(6'h00, 1'b0, 2'b11, 32'hFFFF_FFF0);
    scan(6'h00, 1'b0, 2'b10, 32'hFFFF_FFF2);
    scan(6'h00, 1'b0, 2'b00, 32'hFFFF_FFF5);
    scan(6'h00, 1'b0, 2'b01, 32'hFFFF_FFF8);
    scan(6'h2A, 1'b0, 2'b01, 32'h0000_0004);
    scan(6'h2A, 1'b0, 2'b01, 32'h0000_000C);
    scan(6'h2A, 1'b1, 2'b01, 32'h0000_0011);
    scan(6'h2A, 1'b1, 2'b01, 32'h0000_0016);
    scan(6'h2A, 1'b1, 2'b01, 32'h8000_0016);

    // Random phases, each under its own register setting.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p != 0) begin
        drain();
        case (p)
          1: set_regs(8'd0, 8'hE0, 8'd0);
          2: set_regs(8'd255, 8'd16, 8'd255);
          3: set_regs(8'd1, 8'd1, 8'd1);
          4: set_regs(8'd9, 8'd31, 8'd7);
          default: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(1, 16)),
                            8'($urandom_range(1, 255)));
        endcase
      end
      for (int i = 0; i < PHASE_SCANS; i++) begin
        no_idle = (i % 40) < 8;
        if (p == 0 && i == 30) hold_req++;
        rand_scan();
      end
    end
    no_idle = 1'b0;

    // Pile-up: with the time frozen the pulse never ends, so the steps
    // build up clockwise and then swing over to counterclockwise.
    drain();
    set_regs(8'd5, 8'd1, 8'd255);
    no_idle = 1'b1;
    scan(cur_keys, cur_sw, cur_ph, cur_t + 32'd1000);
    repeat (PILE_STEPS) scan(cur_keys, cur_sw, quad_next(cur_ph, 1'b0), cur_t);
    repeat (2 * PILE_STEPS) scan(cur_keys, cur_sw, quad_next(cur_ph, 1'b1), cur_t);
    no_idle = 1'b0;

    // Release, then a single-item pulse drawn from the piled-up count.
    drain();
    set_regs(8'd5, 8'd16, 8'd0);
    for (int k = 0; k < PILE_STEPS; k++)
      scan(cur_keys, cur_sw, cur_ph, cur_t + ((k == 0) ? 32'd300 : 32'd1));

    drain();
    $display("Run covered %0d scans and %0d checked results over %0d register settings.",
             scans_seen, results_seen, settings_used);
    $display("Pulses started: %0d cw, %0d ccw; step count clamped %0d times.",
             cw_starts, ccw_starts, sat_hits);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("Timeout: the block stopped moving items.");
    $display("FAIL");
    $finish;
  end

endmodule
